/* src/cdt_pkg.sv */
// Shared types and constants for the calendar date to tick converter.
`timescale 1ns / 1ps

package cdt_pkg;

    // Input beat: one calendar date and time of day.
    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [29:0] nanos;
    } date_in_t;

    // Output beat: range flag and 100 ns tick count.
    typedef struct packed {
        logic        valid_res;
        logic [61:0] ticks;
    } ticks_out_t;

    // Range limits.
    localparam logic [13:0] YEAR_MAX   = 14'd9999;
    localparam logic [3:0]  MONTH_MAX  = 4'd12;
    localparam logic [4:0]  HOUR_MAX   = 5'd23;
    localparam logic [5:0]  MINSEC_MAX = 6'd59;
    localparam logic [29:0] NANOS_MAX  = 30'd999999999;

    // Tick scales split into an odd part and a power-of-two shift.
    // day = 52734375 << 14, hour = 17578125 << 11,
    // minute = 1171875 << 9, second = 78125 << 7.
    localparam logic [25:0] DAY_ODD    = 26'd52734375;
    localparam int unsigned DAY_SHIFT  = 14;
    localparam logic [24:0] HOUR_ODD   = 25'd17578125;
    localparam int unsigned HOUR_SHIFT = 11;
    localparam logic [20:0] MIN_ODD    = 21'd1171875;
    localparam int unsigned MIN_SHIFT  = 9;
    localparam logic [16:0] SEC_ODD    = 17'd78125;
    localparam int unsigned SEC_SHIFT  = 7;

    // Reciprocals: x/100 = (x*5243)>>19 and x/400 = (x*10486)>>22 for x < 16384,
    // n/100 = (n*0x51EB851F)>>37 for any 32-bit n.
    localparam logic [12:0] RECIP_100     = 13'd5243;
    localparam int unsigned RECIP_100_SH  = 19;
    localparam logic [13:0] RECIP_400     = 14'd10486;
    localparam int unsigned RECIP_400_SH  = 22;
    localparam logic [31:0] RECIP_NS      = 32'h51EB851F;
    localparam int unsigned RECIP_NS_SH   = 37;
    localparam logic [8:0]  DAYS_PER_YEAR = 9'd365;

    // Stage 1 to stage 2: checked flags and raw products.
    typedef struct packed {
        logic        ok;
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [11:0] py_q4;
        logic [21:0] py_365;
        logic [26:0] py_p100;
        logic [27:0] py_p400;
        logic [26:0] yr_p100;
        logic [29:0] hour_p;
        logic [26:0] min_p;
        logic [22:0] sec_p;
        logic [61:0] ns_p;
    } s1_t;

    // Stage 3 to stage 4: day count and time-of-day ticks.
    typedef struct packed {
        logic        ok;
        logic [21:0] days;
        logic [40:0] tod;
    } s3_t;

endpackage

/* src/cdt_front.sv */
// Input stage: most range checks and the constant products passed on in s1_t.
`timescale 1ns / 1ps

module cdt_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             up_valid,
    output logic             up_stall,
    input  cdt_pkg::date_in_t up_data,
    output logic             dn_valid,
    input  logic             dn_stall,
    output cdt_pkg::s1_t     dn_data
);
    import cdt_pkg::*;

    logic v_reg;
    s1_t  d_reg;
    s1_t  d_next;
    logic [13:0] py;

    // Hold while a beat waits downstream.
    assign up_stall = v_reg & dn_stall;
    assign dn_valid = v_reg;
    assign dn_data  = d_reg;

    // Check ranges and form products.
    always_comb
    begin
        py             = up_data.year - 14'd1;
        d_next.ok      = (up_data.year != 14'd0) && (up_data.year <= YEAR_MAX) &&
                         (up_data.month != 4'd0) && (up_data.month <= MONTH_MAX) &&
                         (up_data.day != 5'd0) && (up_data.hour <= HOUR_MAX) &&
                         (up_data.minute <= MINSEC_MAX) &&
                         (up_data.second <= MINSEC_MAX) &&
                         (up_data.nanos <= NANOS_MAX);
        d_next.year    = up_data.year;
        d_next.month   = up_data.month;
        d_next.day     = up_data.day;
        d_next.py_q4   = py[13:2];
        d_next.py_365  = 22'(py * DAYS_PER_YEAR);
        d_next.py_p100 = 27'(py * RECIP_100);
        d_next.py_p400 = 28'(py * RECIP_400);
        d_next.yr_p100 = 27'(up_data.year * RECIP_100);
        d_next.hour_p  = 30'(up_data.hour * HOUR_ODD);
        d_next.min_p   = 27'(up_data.minute * MIN_ODD);
        d_next.sec_p   = 23'(up_data.second * SEC_ODD);
        d_next.ns_p    = 62'({2'b00, up_data.nanos} * RECIP_NS);
    end

    // Advance the valid bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (!up_stall)
        begin
            v_reg <= up_valid;
        end
    end

    // Load the payload.
    always_ff @(posedge clk)
    begin
        if (!up_stall && up_valid)
        begin
            d_reg <= d_next;
        end
    end

endmodule

/* src/cdt_date.sv */
// Date stages: leap rule, days since year 1 and time-of-day ticks.
`timescale 1ns / 1ps

module cdt_date (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         up_valid,
    output logic         up_stall,
    input  cdt_pkg::s1_t up_data,
    output logic         dn_valid,
    input  logic         dn_stall,
    output cdt_pkg::s3_t dn_data
);
    import cdt_pkg::*;

    typedef struct packed {
        logic        ok;
        logic        leap;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [21:0] days_base;
        logic [40:0] tod;
    } s2_t;

    // Days before the first of month m (1..12).
    function automatic logic [8:0] month_start(input logic leap, input logic [3:0] m);
        logic [8:0] r;
        unique case (m)
            4'd1:    r = 9'd0;
            4'd2:    r = 9'd31;
            4'd3:    r = 9'd59;
            4'd4:    r = 9'd90;
            4'd5:    r = 9'd120;
            4'd6:    r = 9'd151;
            4'd7:    r = 9'd181;
            4'd8:    r = 9'd212;
            4'd9:    r = 9'd243;
            4'd10:   r = 9'd273;
            4'd11:   r = 9'd304;
            4'd12:   r = 9'd334;
            default: r = 9'd0;
        endcase
        if (leap && (m > 4'd2) && (m <= MONTH_MAX))
        begin
            r = r + 9'd1;
        end
        return r;
    endfunction

    // Length of month m (1..12).
    function automatic logic [4:0] month_len(input logic leap, input logic [3:0] m);
        logic [4:0] r;
        unique case (m)
            4'd2:    r = leap ? 5'd29 : 5'd28;
            4'd4,
            4'd6,
            4'd9,
            4'd11:   r = 5'd30;
            default: r = 5'd31;
        endcase
        return r;
    endfunction

    logic        v2_reg;
    logic        v3_reg;
    s2_t         d2_reg;
    s2_t         d2_next;
    s3_t         d3_reg;
    s3_t         d3_next;
    logic        stall3;
    logic [7:0]  yr_q100;
    logic [13:0] yr_c100;
    logic [24:0] ns_q;

    // Back-pressure per stage; empty stages absorb bubbles.
    assign stall3   = v3_reg & dn_stall;
    assign up_stall = v2_reg & stall3;
    assign dn_valid = v3_reg;
    assign dn_data  = d3_reg;

    // Stage 2: leap rule, day count without month, time-of-day sum.
    always_comb
    begin
        yr_q100           = up_data.yr_p100[26:RECIP_100_SH];
        yr_c100           = 14'(yr_q100 * 7'd100);
        ns_q              = up_data.ns_p[61:RECIP_NS_SH];
        d2_next.ok        = up_data.ok;
        d2_next.month     = up_data.month;
        d2_next.day       = up_data.day;
        d2_next.leap      = (up_data.year[1:0] == 2'b00) &&
                            ((up_data.year != yr_c100) || (yr_q100[1:0] == 2'b00));
        d2_next.days_base = up_data.py_365 + 22'(up_data.py_q4)
                            - 22'(up_data.py_p100[26:RECIP_100_SH])
                            + 22'(up_data.py_p400[27:RECIP_400_SH]);
        d2_next.tod       = ({11'd0, up_data.hour_p} << HOUR_SHIFT)
                            + ({14'd0, up_data.min_p} << MIN_SHIFT)
                            + ({18'd0, up_data.sec_p} << SEC_SHIFT)
                            + {16'd0, ns_q};
    end

    // Stage 3: month offset and day-of-month check.
    always_comb
    begin
        d3_next.ok   = d2_reg.ok && (d2_reg.day <= month_len(d2_reg.leap, d2_reg.month));
        d3_next.days = d2_reg.days_base
                       + 22'(month_start(d2_reg.leap, d2_reg.month))
                       + 22'(d2_reg.day) - 22'd1;
        d3_next.tod  = d2_reg.tod;
    end

    // Advance the valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (!up_stall)
            begin
                v2_reg <= up_valid;
            end
            if (!stall3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    // Load the payloads.
    always_ff @(posedge clk)
    begin
        if (!up_stall && up_valid)
        begin
            d2_reg <= d2_next;
        end
        if (!stall3 && v2_reg)
        begin
            d3_reg <= d3_next;
        end
    end

endmodule

/* src/cdt_tick.sv */
// Tick stages: scale the day count and merge with time of day.
`timescale 1ns / 1ps

module cdt_tick (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               up_valid,
    output logic               up_stall,
    input  cdt_pkg::s3_t       up_data,
    output logic               dn_valid,
    input  logic               dn_stall,
    output cdt_pkg::ticks_out_t dn_data
);
    import cdt_pkg::*;

    typedef struct packed {
        logic        ok;
        logic [47:0] day_p;
        logic [40:0] tod;
    } s4_t;

    logic       v4_reg;
    logic       v5_reg;
    s4_t        d4_reg;
    s4_t        d4_next;
    ticks_out_t d5_reg;
    ticks_out_t d5_next;
    logic       stall5;

    assign stall5   = v5_reg & dn_stall;
    assign up_stall = v4_reg & stall5;
    assign dn_valid = v5_reg;
    assign dn_data  = d5_reg;

    // Stage 4: day count times the odd part of a day.
    always_comb
    begin
        d4_next.ok    = up_data.ok;
        d4_next.day_p = 48'(up_data.days * DAY_ODD);
        d4_next.tod   = up_data.tod;
    end

    // Stage 5: shift, add, and drop the count when out of range.
    always_comb
    begin
        d5_next.valid_res = d4_reg.ok;
        if (d4_reg.ok)
        begin
            d5_next.ticks = 62'({d4_reg.day_p, 14'd0} >> (14 - DAY_SHIFT))
                            + {21'd0, d4_reg.tod};
        end
        else
        begin
            d5_next.ticks = '0;
        end
    end

    // Advance the valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (!up_stall)
            begin
                v4_reg <= up_valid;
            end
            if (!stall5)
            begin
                v5_reg <= v4_reg;
            end
        end
    end

    // Load the payloads.
    always_ff @(posedge clk)
    begin
        if (!up_stall && up_valid)
        begin
            d4_reg <= d4_next;
        end
        if (!stall5 && v4_reg)
        begin
            d5_reg <= d5_next;
        end
    end

endmodule

/* src/calendar_date_to_ticks.sv */
// Throughput: one beat per cycle while no stall holds the pipe; five register stages,
// each with its own valid bit, so a stall only holds stages that are full.
// Reset clears every valid bit; payload registers are not reset.
// Top level: Gregorian date and time of day to 100 ns ticks since year 1.
`timescale 1ns / 1ps

module calendar_date_to_ticks (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  cdt_pkg::date_in_t   req,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output cdt_pkg::ticks_out_t rsp
);
    import cdt_pkg::*;

    logic s1_valid;
    logic s1_stall;
    s1_t  s1_data;
    logic s3_valid;
    logic s3_stall;
    s3_t  s3_data;

    // Range checks and products.
    cdt_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (req_valid),
        .up_stall (req_stall),
        .up_data  (req),
        .dn_valid (s1_valid),
        .dn_stall (s1_stall),
        .dn_data  (s1_data)
    );

    // Leap rule and day count.
    cdt_date u_date (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (s1_valid),
        .up_stall (s1_stall),
        .up_data  (s1_data),
        .dn_valid (s3_valid),
        .dn_stall (s3_stall),
        .dn_data  (s3_data)
    );

    // Day scaling and final sum.
    cdt_tick u_tick (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (s3_valid),
        .up_stall (s3_stall),
        .up_data  (s3_data),
        .dn_valid (rsp_valid),
        .dn_stall (rsp_stall),
        .dn_data  (rsp)
    );

endmodule
